// ===== hdl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the min-heap priority queue: command and result
// beats, operation codes and status codes.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int OCC_W  = 7;

    typedef enum logic
    {
        FUNC_INSERT  = 1'b0,
        FUNC_EXTRACT = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        func_t              func;
        logic [ID_W-1:0]    entry_id;
        logic [TIME_W-1:0]  enq_time;
    } mhpq_cmd_t;

    typedef struct packed
    {
        status_t            status;
        logic [ID_W-1:0]    out_id;
        logic [TIME_W-1:0]  out_time;
        logic [OCC_W-1:0]   occupancy;
    } mhpq_res_t;

endpackage

// ===== hdl/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// mhpq_ram
// Heap entry store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hdl/min_heap_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit
// Binary min-heap priority queue keyed on arrival time. Insert appends an
// entry and sifts it up; extract returns the root and sifts the last entry
// down from the root.
// ----------------------------------------------------------------------------
//
//   channel   ports                    handshake
//   -------   ----------------------   ---------------------------------------
//   command   cmd (mhpq_cmd_t)         beat taken when start && !busy
//   result    result (mhpq_res_t)      beat shown for one cycle while done
//
// Timing: one command at a time; full insert and empty extract show done in
// the cycle after the accept. Each level walked passes through a read state
// and a compare/write-back state; an insert ends at the root or where it
// stops below its parent, an extract at a leaf or where it stops. Reset
// clears control state and the count, not the heap memory.
// Stalls: the receiver cannot stall; a new command may be taken in the done
// cycle.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit #(
    parameter int DEPTH    = 64,
    parameter int ID_BITS  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mhpq_pkg::mhpq_cmd_t   cmd,
    output logic                  done,
    output mhpq_pkg::mhpq_res_t   result
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = AW + 2;           // child index, wide enough to overflow DEPTH
    localparam int WW = ID_BITS + KEY_BITS;

    typedef enum logic [5:0]
    {
        ST_IDLE   = 6'b000001,
        ST_UP_RD  = 6'b000010,
        ST_UP_CMP = 6'b000100,
        ST_EX_LD  = 6'b001000,
        ST_DN_RD  = 6'b010000,
        ST_DN_CMP = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        pos_reg, pos_next;       // hole position
    logic [CW-1:0]        cnt_reg, cnt_next;       // entries held
    logic [ID_BITS-1:0]   cid_reg, cid_next;       // entry being moved
    logic [KEY_BITS-1:0]  ckey_reg, ckey_next;
    status_t              status_reg, status_next;
    logic [ID_W-1:0]      oid_reg, oid_next;
    logic [TIME_W-1:0]    otime_reg, otime_next;
    logic                 done_reg, done_next;

    // memory port controls
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WW-1:0]        mem_wdata;
    logic [AW-1:0]        mem_raddr_a;
    logic [AW-1:0]        mem_raddr_b;
    logic [WW-1:0]        mem_rdata_a;
    logic [WW-1:0]        mem_rdata_b;

    logic [ID_BITS-1:0]   rd_a_id, rd_b_id;
    logic [KEY_BITS-1:0]  rd_a_key, rd_b_key;

    // index arithmetic
    logic [AW-1:0]        pos_m1;
    logic [AW-1:0]        parent;
    logic [CW-1:0]        cnt_m1;
    logic [LW-1:0]        lc_w, rc_w, cnt_w;
    logic                 lc_in, rc_in;
    logic                 pick_rc;
    logic [AW-1:0]        pick_addr;
    logic [ID_BITS-1:0]   pick_id;
    logic [KEY_BITS-1:0]  pick_key;

    mhpq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WW)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .rdata_a (mem_rdata_a),
        .raddr_b (mem_raddr_b),
        .rdata_b (mem_rdata_b)
    );

    assign rd_a_id  = mem_rdata_a[WW-1:KEY_BITS];
    assign rd_a_key = mem_rdata_a[KEY_BITS-1:0];
    assign rd_b_id  = mem_rdata_b[WW-1:KEY_BITS];
    assign rd_b_key = mem_rdata_b[KEY_BITS-1:0];

    assign pos_m1 = pos_reg - AW'(1);
    assign parent = pos_m1 >> 1;
    assign cnt_m1 = cnt_reg - CW'(1);

    // children of the hole, compared against the live count
    assign lc_w  = {1'b0, pos_reg, 1'b1};
    assign rc_w  = lc_w + LW'(1);
    assign cnt_w = LW'(cnt_reg);
    assign lc_in = (lc_w < cnt_w);
    assign rc_in = (rc_w < cnt_w);

    // strictly smaller child wins; left child on a tie
    assign pick_rc   = rc_in && (rd_b_key < rd_a_key);
    assign pick_addr = pick_rc ? rc_w[AW-1:0] : lc_w[AW-1:0];
    assign pick_id   = pick_rc ? rd_b_id  : rd_a_id;
    assign pick_key  = pick_rc ? rd_b_key : rd_a_key;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        cid_next    = cid_reg;
        ckey_next   = ckey_reg;
        status_next = status_reg;
        oid_next    = oid_reg;
        otime_next  = otime_reg;
        done_next   = 1'b0;

        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = {cid_reg, ckey_reg};
        mem_raddr_a = parent;
        mem_raddr_b = parent;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // take the command beat
                    status_next = STATUS_OK;
                    oid_next    = '0;
                    otime_next  = '0;
                    cid_next    = ID_BITS'(cmd.entry_id);
                    ckey_next   = KEY_BITS'(cmd.enq_time);
                    if (cmd.func == FUNC_INSERT)
                    begin
                        if (cnt_reg == CW'(DEPTH))
                        begin
                            status_next = STATUS_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            // open a hole at the tail and walk it up
                            pos_next   = cnt_reg[AW-1:0];
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = ST_UP_RD;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            // fetch root and last entry together
                            mem_raddr_a = '0;
                            mem_raddr_b = cnt_m1[AW-1:0];
                            state_next  = ST_EX_LD;
                        end
                    end
                end
            end

            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                mem_we = 1'b1;
                if (rd_a_key > ckey_reg)
                begin
                    // move the parent down into the hole and advance up
                    mem_wdata  = mem_rdata_a;
                    pos_next   = parent;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_EX_LD:
            begin
                oid_next   = ID_W'(rd_a_id);
                otime_next = TIME_W'(rd_a_key);
                cid_next   = rd_b_id;
                ckey_next  = rd_b_key;
                cnt_next   = cnt_m1;
                pos_next   = '0;
                state_next = ST_DN_RD;
            end

            ST_DN_RD:
            begin
                mem_raddr_a = lc_w[AW-1:0];
                mem_raddr_b = rc_w[AW-1:0];
                if (lc_in)
                begin
                    state_next = ST_DN_CMP;
                end
                else
                begin
                    // leaf reached: drop the moved entry here
                    mem_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DN_CMP:
            begin
                mem_we = 1'b1;
                if (pick_key < ckey_reg)
                begin
                    mem_wdata  = {pick_id, pick_key};
                    pos_next   = pick_addr;
                    state_next = ST_DN_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        cid_reg    <= cid_next;
        ckey_reg   <= ckey_next;
        status_reg <= status_next;
        oid_reg    <= oid_next;
        otime_reg  <= otime_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    always_comb
    begin
        result.status    = status_reg;
        result.out_id    = oid_reg;
        result.out_time  = otime_reg;
        result.occupancy = OCC_W'(cnt_reg);
    end

endmodule

// ===== tb/min_heap_priority_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit_tb
// Self-checking bench for the min-heap priority queue. A tracker keeps its
// own copy of the heap and predicts the status, extracted entry and
// occupancy of every command beat. Directed beats cover the field extremes,
// an empty heap and equal keys. Randomized phases then fill and drain the
// heap, with random gaps between beats outside the gapless phases.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit_tb;

    import mhpq_pkg::*;

    localparam int HEAP_DEPTH     = 64;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_BEATS    = 100;

    // ------------------------------------------------------------------------
    // Heap tracker: mirrors the queue contents and holds the result beats
    // still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class heap_tracker;
        logic [ID_W-1:0]   slot_id  [HEAP_DEPTH];
        logic [TIME_W-1:0] slot_key [HEAP_DEPTH];
        int                fill;
        int                error_count;
        mhpq_res_t         owed_results[$];

        function new();
            fill        = 0;
            error_count = 0;
        endfunction

        function void swap_slots(int a, int b);
            logic [ID_W-1:0]   tid;
            logic [TIME_W-1:0] tkey;
            tid         = slot_id[a];
            tkey        = slot_key[a];
            slot_id[a]  = slot_id[b];
            slot_key[a] = slot_key[b];
            slot_id[b]  = tid;
            slot_key[b] = tkey;
        endfunction

        // Apply one accepted command and queue the result it must produce.
        function void note_command(mhpq_cmd_t c);
            mhpq_res_t r;
            int        pos;
            int        parent;
            int        lc;
            int        pick;
            bit        settled;
            r        = '0;
            r.status = STATUS_OK;
            if (c.func == FUNC_INSERT)
            begin
                if (fill >= HEAP_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    slot_id[fill]  = c.entry_id;
                    slot_key[fill] = c.enq_time;
                    pos            = fill;
                    fill++;
                    // sift up while the parent key is strictly greater
                    settled = 1'b0;
                    while (pos > 0 && !settled)
                    begin
                        parent = (pos - 1) / 2;
                        if (slot_key[parent] > slot_key[pos])
                        begin
                            swap_slots(parent, pos);
                            pos = parent;
                        end
                        else
                            settled = 1'b1;
                    end
                end
            end
            else
            begin
                if (fill == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    r.out_id   = slot_id[0];
                    r.out_time = slot_key[0];
                    fill--;
                    if (fill > 0)
                    begin
                        slot_id[0]  = slot_id[fill];
                        slot_key[0] = slot_key[fill];
                        pos         = 0;
                        // sift down: smaller child, left on a tie
                        settled = 1'b0;
                        while (!settled)
                        begin
                            lc = 2 * pos + 1;
                            if (lc >= fill)
                                settled = 1'b1;
                            else
                            begin
                                pick = lc;
                                if (lc + 1 < fill && slot_key[lc + 1] < slot_key[lc])
                                    pick = lc + 1;
                                if (slot_key[pick] < slot_key[pos])
                                begin
                                    swap_slots(pick, pos);
                                    pos = pick;
                                end
                                else
                                    settled = 1'b1;
                            end
                        end
                    end
                end
            end
            r.occupancy = OCC_W'(fill);
            owed_results.push_back(r);
        endfunction

        // Compare one result beat against the oldest owed result.
        function void check_result(mhpq_res_t got);
            mhpq_res_t want;
            if (owed_results.size() == 0)
            begin
                $error("result beat with no command outstanding");
                error_count++;
                return;
            end
            want = owed_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                error_count++;
            end
            if (got.out_id !== want.out_id)
            begin
                $error("out_id: expected %0h, got %0h", want.out_id, got.out_id);
                error_count++;
            end
            if (got.out_time !== want.out_time)
            begin
                $error("out_time: expected %0h, got %0h", want.out_time, got.out_time);
                error_count++;
            end
            if (got.occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                error_count++;
            end
        endfunction

        function int owed_count();
            return owed_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      done;
    mhpq_cmd_t cmd;
    mhpq_res_t result;

    heap_tracker tracker;
    int          quiet_cycles;
    bit          gapless;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    min_heap_priority_queue_unit #(
        .DEPTH    (HEAP_DEPTH),
        .ID_BITS  (ID_W),
        .KEY_BITS (TIME_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Check a result before
    // noting a new command, since a command can be taken in the done cycle.
    // Count quiet cycles and end the run if the block stops moving.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_result(result);
            if (start && !busy)
                tracker.note_command(cmd);
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: idle for a random gap (none in gapless phases), then raise
    // start with the beat and hold it until the block takes it. Keep start
    // high across back-to-back beats so it gets one assignment per step.
    // ------------------------------------------------------------------------
    task automatic issue_beat(input mhpq_cmd_t c);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic issue_op(input func_t f, input logic [ID_W-1:0] id,
                            input logic [TIME_W-1:0] key);
        mhpq_cmd_t c;
        c.func     = f;
        c.entry_id = id;
        c.enq_time = key;
        issue_beat(c);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int        phase;
        int        n;
        int        insert_pct;
        mhpq_cmd_t c;

        tracker      = new();
        quiet_cycles = 0;
        gapless      = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extract from an empty heap, field extremes, equal keys.
        issue_op(FUNC_EXTRACT, 16'hFFFF, 32'hFFFF_FFFF);
        issue_op(FUNC_INSERT,  16'h0000, 32'hFFFF_FFFF);
        issue_op(FUNC_INSERT,  16'hFFFF, 32'h0000_0000);
        issue_op(FUNC_INSERT,  16'h1234, 32'h0000_0005);
        // equal keys: sift-up stops on an equal parent
        issue_op(FUNC_INSERT,  16'h0002, 32'h0000_0005);
        issue_op(FUNC_INSERT,  16'h0003, 32'h0000_0005);
        issue_op(FUNC_INSERT,  16'h0004, 32'h0000_0005);
        issue_op(FUNC_INSERT,  16'h5555, 32'hAAAA_AAAA);
        issue_op(FUNC_INSERT,  16'hAAAA, 32'h5555_5555);
        // drain past empty: ties pick the left child on sift-down
        repeat (9) issue_op(FUNC_EXTRACT, 16'h0000, 32'h0000_0000);
        // descending keys force a full-height sift-up
        issue_op(FUNC_INSERT,  16'h0010, 32'h0000_0030);
        issue_op(FUNC_INSERT,  16'h0011, 32'h0000_0020);
        issue_op(FUNC_INSERT,  16'h0012, 32'h0000_0010);
        issue_op(FUNC_INSERT,  16'h0013, 32'h0000_0000);

        // Random phases: insert-heavy phases push the heap to full,
        // extract-heavy ones drain it to empty, balanced ones churn it.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 3)
                0:       insert_pct = 85;
                1:       insert_pct = 20;
                default: insert_pct = 55;
            endcase
            gapless = (phase % 4 == 3);
            for (n = 0; n < PHASE_BEATS; n++)
            begin
                c.func     = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT
                                                                  : FUNC_EXTRACT;
                c.entry_id = ID_W'($urandom());
                // mostly small keys so that ties are common
                case ($urandom_range(0, 3))
                    0, 1:    c.enq_time = TIME_W'($urandom_range(0, 15));
                    2:       c.enq_time = TIME_W'($urandom());
                    default: c.enq_time = $urandom_range(0, 1) ? '1 : '0;
                endcase
                issue_beat(c);
            end
        end
        start <= 1'b0;

        // Wait for every owed result, then let the block settle.
        while (tracker.owed_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
